>>> rtl/sliding_window_median_top_defines.svh
// ----------------------------------------------------------------------------
// Sliding window median assertion macros
// Shared property forms for the port checker of the running median filter.
// ----------------------------------------------------------------------------
`ifndef SLIDING_WINDOW_MEDIAN_TOP_DEFINES_SVH
`define SLIDING_WINDOW_MEDIAN_TOP_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define SWM_ASSERT_IMP(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("sliding window median: assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define SWM_ASSERT_NXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("sliding window median: assertion failed");

`endif

>>> rtl/swm_pkg.sv
// ----------------------------------------------------------------------------
// Sliding window median package
// Payload types and fixed constants of the running median filter.
// ----------------------------------------------------------------------------
package swm_pkg;

	localparam int SAMPLE_W = 32;
	localparam int MEDIAN_W = 33;
	localparam int CFG_W    = 7;

	typedef logic signed [SAMPLE_W-1:0] sample_t;
	typedef logic signed [MEDIAN_W-1:0] median_t;
	typedef logic [CFG_W-1:0]           win_size_t;

	localparam win_size_t WINDOW_RESET = win_size_t'(3);

endpackage

>>> rtl/sliding_window_median_top.sv
// ----------------------------------------------------------------------------
// Sliding window median top level
// Running median over the last min(window_size, WINDOW_MAX) samples, doubled.
// ----------------------------------------------------------------------------
// A sample goes to ST_INS, passing ST_RING and ST_RM first if the window is full;
// once the window is full, ST_MED_A/B/C and ST_OUT follow, and a stalled sink
// holds the result in ST_OUT. No new sample is taken until the last is done, as
// the read port of the sorted store serves removal, insertion and median reads.
// A zero window takes one cycle per sample while cfg_valid is low, gives nothing.
// Reset empties the window and sets window_size to 3; the stores keep data.
// ----------------------------------------------------------------------------
module sliding_window_median_top #(
	parameter int WINDOW_MAX = 64
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cfg_valid,
	output logic              cfg_ready,
	input  swm_pkg::win_size_t window_size,
	input  logic              in_valid,
	output logic              in_ready,
	input  swm_pkg::sample_t  sample,
	output logic              out_valid,
	input  logic              out_ready,
	output swm_pkg::median_t  median_doubled
);

	import swm_pkg::*;

	localparam int CW = $clog2(WINDOW_MAX + 1);
	localparam int AW = (WINDOW_MAX > 1) ? $clog2(WINDOW_MAX) : 1;
	localparam int XW = (CW > CFG_W) ? CW : CFG_W;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_RING,
		ST_RM,
		ST_INS,
		ST_MED_A,
		ST_MED_B,
		ST_MED_C,
		ST_OUT
	} state_t;

	state_t          state_q;
	win_size_t       win_q;
	logic [CW-1:0]   fill_q;
	logic [AW-1:0]   rp_q;
	logic [CW-1:0]   rd_addr_q;
	logic            pend_s1;
	logic [AW-1:0]   addr_s1;
	logic            found_q;
	logic            stop_q;
	sample_t         v_q;
	logic [SAMPLE_W-1:0] old_q;
	median_t         acc_q;
	median_t         res_q;
	logic            out_valid_q;
	median_t         out_q;

	logic [CW-1:0]   k;
	logic            in_acc;
	logic            cfg_acc;
	logic            rm_issue;
	logic            ins_issue;
	logic            ins_done;
	logic            out_load;
	logic [CW-1:0]   rd_addr_m1;

	logic            ring_wr_en;
	logic            ring_rd_en;
	logic [SAMPLE_W-1:0] ring_rd_data;
	logic            srt_wr_en;
	logic [AW-1:0]   srt_wr_addr;
	logic [SAMPLE_W-1:0] srt_wr_data;
	logic            srt_rd_en;
	logic [AW-1:0]   srt_rd_addr;
	logic [SAMPLE_W-1:0] srt_rd_data;

	assign k = (XW'(win_q) > XW'(WINDOW_MAX)) ? CW'(WINDOW_MAX) : CW'(win_q);

	assign cfg_ready      = (state_q == ST_IDLE);
	assign in_ready       = (state_q == ST_IDLE) && !cfg_valid;
	assign in_acc         = in_valid && in_ready;
	assign cfg_acc        = cfg_valid && cfg_ready;
	assign out_valid      = out_valid_q;
	assign median_doubled = out_q;
	assign out_load       = (state_q == ST_OUT) && (!out_valid_q || out_ready);

	assign rd_addr_m1 = CW'(rd_addr_q - 1'b1);
	assign rm_issue   = (rd_addr_q < k);
	assign ins_issue  = (rd_addr_q != '0) && !stop_q;
	assign ins_done   = stop_q || (!pend_s1 && (rd_addr_q == '0));
	assign ring_rd_en = in_acc;
	assign ring_wr_en = (state_q == ST_INS) && ins_done;

	always_comb begin
		srt_wr_en   = 1'b0;
		srt_wr_addr = '0;
		srt_wr_data = v_q;
		srt_rd_en   = 1'b0;
		srt_rd_addr = '0;
		case (state_q)
			ST_RM: begin
				srt_rd_en   = rm_issue;
				srt_rd_addr = rd_addr_q[AW-1:0];
				if (pend_s1 && found_q) begin
					srt_wr_en   = 1'b1;
					srt_wr_addr = AW'(addr_s1 - 1'b1);
					srt_wr_data = srt_rd_data;
				end
			end
			ST_INS: begin
				srt_rd_en   = ins_issue;
				srt_rd_addr = rd_addr_m1[AW-1:0];
				if (pend_s1 && !stop_q) begin
					srt_wr_en   = 1'b1;
					srt_wr_addr = AW'(addr_s1 + 1'b1);
					if ($signed(srt_rd_data) > v_q) begin
						srt_wr_data = srt_rd_data;
					end
				end else if (!stop_q && (rd_addr_q == '0)) begin
					srt_wr_en = 1'b1;
				end
			end
			ST_MED_A: begin
				srt_rd_en   = 1'b1;
				srt_rd_addr = AW'(CW'(k - 1'b1) >> 1);
			end
			ST_MED_B: begin
				srt_rd_en   = 1'b1;
				srt_rd_addr = AW'(k >> 1);
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			win_q       <= WINDOW_RESET;
			fill_q      <= '0;
			rp_q        <= '0;
			rd_addr_q   <= '0;
			pend_s1     <= 1'b0;
			addr_s1     <= '0;
			found_q     <= 1'b0;
			stop_q      <= 1'b0;
			v_q         <= '0;
			old_q       <= '0;
			acc_q       <= '0;
			res_q       <= '0;
			out_valid_q <= 1'b0;
			out_q       <= '0;
		end else begin
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && out_ready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					pend_s1 <= 1'b0;
					stop_q  <= 1'b0;
					found_q <= 1'b0;
					if (cfg_acc && (window_size != win_q)) begin
						win_q  <= window_size;
						fill_q <= '0;
						rp_q   <= '0;
					end else if (in_acc && (k != '0)) begin
						v_q <= sample;
						if (fill_q >= k) begin
							state_q <= ST_RING;
						end else begin
							rd_addr_q <= fill_q;
							state_q   <= ST_INS;
						end
					end
				end
				ST_RING: begin
					old_q     <= ring_rd_data;
					rd_addr_q <= '0;
					state_q   <= ST_RM;
				end
				ST_RM: begin
					pend_s1 <= rm_issue;
					addr_s1 <= rd_addr_q[AW-1:0];
					if (rm_issue) begin
						rd_addr_q <= CW'(rd_addr_q + 1'b1);
					end
					if (pend_s1 && !found_q && (srt_rd_data == old_q)) begin
						found_q <= 1'b1;
					end
					if (!rm_issue && !pend_s1) begin
						fill_q    <= CW'(k - 1'b1);
						rd_addr_q <= CW'(k - 1'b1);
						state_q   <= ST_INS;
					end
				end
				ST_INS: begin
					pend_s1 <= ins_issue;
					addr_s1 <= rd_addr_m1[AW-1:0];
					if (ins_issue) begin
						rd_addr_q <= rd_addr_m1;
					end
					if (pend_s1 && !stop_q && !($signed(srt_rd_data) > v_q)) begin
						stop_q <= 1'b1;
					end
					if (ins_done) begin
						fill_q  <= CW'(fill_q + 1'b1);
						rp_q    <= (CW'(rp_q + 1'b1) >= k) ? '0 : AW'(rp_q + 1'b1);
						state_q <= (CW'(fill_q + 1'b1) == k) ? ST_MED_A : ST_IDLE;
					end
				end
				ST_MED_A: begin
					state_q <= ST_MED_B;
				end
				ST_MED_B: begin
					acc_q   <= median_t'($signed(srt_rd_data));
					state_q <= ST_MED_C;
				end
				ST_MED_C: begin
					res_q   <= median_t'(acc_q + median_t'($signed(srt_rd_data)));
					state_q <= ST_OUT;
				end
				ST_OUT: begin
					if (out_load) begin
						out_q   <= res_q;
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	swm_ram #(
		.WIDTH(SAMPLE_W),
		.DEPTH(WINDOW_MAX)
	) u_ring_ram (
		.clk     (clk),
		.wr_en   (ring_wr_en),
		.wr_addr (rp_q),
		.wr_data (v_q),
		.rd_en   (ring_rd_en),
		.rd_addr (rp_q),
		.rd_data (ring_rd_data)
	);

	swm_ram #(
		.WIDTH(SAMPLE_W),
		.DEPTH(WINDOW_MAX)
	) u_sort_ram (
		.clk     (clk),
		.wr_en   (srt_wr_en),
		.wr_addr (srt_wr_addr),
		.wr_data (srt_wr_data),
		.rd_en   (srt_rd_en),
		.rd_addr (srt_rd_addr),
		.rd_data (srt_rd_data)
	);

endmodule

>>> rtl/swm_ram.sv
// ----------------------------------------------------------------------------
// Sliding window median RAM
// Generic simple dual-port memory with one write port and a registered read.
// ----------------------------------------------------------------------------
module swm_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 64
) (
	input  logic                                      clk,
	input  logic                                      wr_en,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
	input  logic [WIDTH-1:0]                          wr_data,
	input  logic                                      rd_en,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
	output logic [WIDTH-1:0]                          rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data <= mem_q[rd_addr];
		end
	end

endmodule

>>> rtl/sliding_window_median_chk.sv
// ----------------------------------------------------------------------------
// Sliding window median port checker
// Watches the ports of the running median filter and is bound to its top.
// ----------------------------------------------------------------------------
`include "sliding_window_median_top_defines.svh"

module sliding_window_median_chk (
	input logic             clk,
	input logic             arst_n,
	input logic             cfg_valid,
	input logic             cfg_ready,
	input logic             in_valid,
	input logic             in_ready,
	input logic             out_valid,
	input logic             out_ready,
	input swm_pkg::median_t median_doubled
);

	import swm_pkg::*;

	// A result beat waiting for the sink keeps its value.
	`SWM_ASSERT_NXT(a_out_hold, clk, arst_n, out_valid && !out_ready, out_valid && $stable(median_doubled))
	// Samples are only taken while configuration could also be taken.
	`SWM_ASSERT_IMP(a_in_idle, clk, arst_n, in_ready, cfg_ready)
	// A new result is posted as the sequencer returns to idle.
	`SWM_ASSERT_IMP(a_out_idle, clk, arst_n, $rose(out_valid), cfg_ready)
	// No result follows a sample beat in the very next cycle.
	`SWM_ASSERT_NXT(a_no_bypass, clk, arst_n, in_valid && in_ready, !$rose(out_valid))

endmodule

bind sliding_window_median_top sliding_window_median_chk u_chk (.*);

>>> verif/sliding_window_median_top_test.sv
// ----------------------------------------------------------------------------
// Sliding window median testbench
// Streams signed samples through the running median filter under several
// window sizes and handshake idling patterns. A class-based scoreboard keeps
// its own ring and sorted copy of the window, predicts each doubled median,
// and compares every output beat against the oldest expectation.
// ----------------------------------------------------------------------------
module sliding_window_median_top_test;
	timeunit 1ns;
	timeprecision 1ps;

	import swm_pkg::*;

	localparam int WIN_LIMIT    = 64;
	localparam int SETTLE_TICKS = 2 * WIN_LIMIT + 16;
	localparam int HOLD_TICKS   = 400;
	localparam int ITEM_TARGET  = 1000;

	typedef enum int {IDLE_NONE, IDLE_SEND, IDLE_RECV, IDLE_BOTH} idle_mode_e;

	class running_median_check;
		sample_t     arrival[WIN_LIMIT];
		sample_t     ordered[WIN_LIMIT];
		int unsigned oldest;
		int unsigned held;
		win_size_t   win;
		median_t     medians_due[$];
		int          errors;

		function new();
			win    = WINDOW_RESET;
			oldest = 0;
			held   = 0;
			errors = 0;
		endfunction

		function void set_window(win_size_t v);
			if (v != win) begin
				win    = v;
				held   = 0;
				oldest = 0;
			end
		endfunction

		function int pending();
			return medians_due.size();
		endfunction

		function void take_sample(sample_t s);
			int unsigned k;
			int unsigned i;
			bit          found;
			sample_t     victim;
			median_t     due;
			k = (win > WIN_LIMIT) ? WIN_LIMIT : win;
			if (k == 0)
				return;
			if (oldest >= k)
				oldest = 0;
			if (held >= k) begin
				victim = arrival[oldest];
				found  = 1'b0;
				for (i = 0; i < held; i++) begin
					if (!found && ordered[i] == victim)
						found = 1'b1;
					if (found && i + 1 < held)
						ordered[i] = ordered[i + 1];
				end
				if (found)
					held--;
				if (held >= k)
					held = k - 1;
			end
			i = held;
			while (i > 0 && ordered[i - 1] > s) begin
				ordered[i] = ordered[i - 1];
				i--;
			end
			ordered[i] = s;
			held++;
			arrival[oldest] = s;
			oldest = (oldest + 1 >= k) ? 0 : oldest + 1;
			if (held < k)
				return;
			if (k % 2 == 1)
				due = {ordered[k / 2], 1'b0};
			else
				due = {ordered[k / 2 - 1][SAMPLE_W-1], ordered[k / 2 - 1]}
					+ {ordered[k / 2][SAMPLE_W-1], ordered[k / 2]};
			medians_due = {medians_due, due};
		endfunction

		function void check_median(median_t got);
			median_t want;
			if (medians_due.size() == 0) begin
				$display("%t: unexpected median beat, expected none, got %0d", $time, got);
				errors++;
				return;
			end
			want = medians_due.pop_front();
			if (got !== want) begin
				$display("%t: median mismatch, expected %0d, got %0d", $time, want, got);
				errors++;
			end
		endfunction
	endclass

	logic      clk;
	logic      arst_n      = 1'b0;
	logic      cfg_valid   = 1'b0;
	logic      cfg_ready;
	win_size_t window_size = '0;
	logic      in_valid    = 1'b0;
	logic      in_ready;
	sample_t   sample      = '0;
	logic      out_valid;
	logic      out_ready   = 1'b0;
	median_t   median_doubled;

	running_median_check sb = new();
	int send_idle  = 0;
	int recv_stall = 0;
	bit hold_request = 1'b0;

	sliding_window_median_top dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.window_size   (window_size),
		.in_valid      (in_valid),
		.in_ready      (in_ready),
		.sample        (sample),
		.out_valid     (out_valid),
		.out_ready     (out_ready),
		.median_doubled(median_doubled)
	);

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	initial begin
		#20_000_000;
		$display("*** FAILED ***");
		$finish;
	end

	initial begin
		int hold_left;
		hold_left = 0;
		forever begin
			@(posedge clk);
			if (arst_n && out_valid && out_ready)
				sb.check_median(median_doubled);
			if (hold_request) begin
				hold_left    = HOLD_TICKS;
				hold_request = 1'b0;
			end
			if (hold_left > 0) begin
				out_ready <= 1'b0;
				hold_left--;
			end else begin
				out_ready <= ($urandom_range(0, 99) >= recv_stall);
			end
		end
	end

	function automatic sample_t pick_sample();
		case ($urandom_range(0, 9))
			7, 8: return sample_t'($urandom_range(0, 8) - 4);
			9: begin
				case ($urandom_range(0, 3))
					0: return 32'sh8000_0000;
					1: return 32'sh7fff_ffff;
					2: return '0;
					default: return '1;
				endcase
			end
			default: return sample_t'($urandom());
		endcase
	endfunction

	task automatic set_idle(idle_mode_e mode);
		case (mode)
			IDLE_SEND: begin
				send_idle  = 45;
				recv_stall = 0;
			end
			IDLE_RECV: begin
				send_idle  = 0;
				recv_stall = 45;
			end
			IDLE_BOTH: begin
				send_idle  = 24;
				recv_stall = 24;
			end
			default: begin
				send_idle  = 0;
				recv_stall = 0;
			end
		endcase
	endtask

	task automatic send_sample(sample_t s);
		while ($urandom_range(0, 99) < send_idle) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		sample   <= s;
		do @(posedge clk); while (!in_ready);
		sb.take_sample(s);
	endtask

	task automatic drain();
		in_valid <= 1'b0;
		do @(posedge clk); while (sb.pending() != 0);
		repeat (SETTLE_TICKS) @(posedge clk);
	endtask

	task automatic write_window(win_size_t v);
		drain();
		cfg_valid   <= 1'b1;
		window_size <= v;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		sb.set_window(v);
	endtask

	initial begin
		sample_t   edge_w3[] = '{0, -1, 1, 32'sh7fff_ffff, 32'sh7fff_ffff,
			32'sh8000_0000, 32'sh8000_0000, 32'sh8000_0000, 5, 5, 5, -7, 3};
		sample_t   edge_w2[] = '{32'sh7fff_ffff, 32'sh7fff_ffff, 32'sh8000_0000,
			32'sh8000_0000, 32'sh7fff_ffff, 0, -1};
		win_size_t fixed_sizes[] = '{1, 5, 5, 4, 3, 0, 64, 65, 127, 2, 8, 0, 33, 63};
		win_size_t v;
		int        sent;
		int        phase;
		int        count;
		int        eff;

		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		sent = 0;
		foreach (edge_w3[i]) begin
			send_sample(edge_w3[i]);
			sent++;
		end
		write_window(2);
		foreach (edge_w2[i]) begin
			send_sample(edge_w2[i]);
			sent++;
		end

		phase = 0;
		while (sent < ITEM_TARGET) begin
			if (phase < fixed_sizes.size())
				v = fixed_sizes[phase];
			else if ($urandom_range(0, 19) == 0)
				v = '0;
			else if ($urandom_range(0, 4) == 0)
				v = win_size_t'($urandom_range(13, 127));
			else
				v = win_size_t'($urandom_range(1, 12));
			write_window(v);
			set_idle(idle_mode_e'(phase % 4));
			if (phase % 8 == 4)
				hold_request = 1'b1;
			eff   = (v > WIN_LIMIT) ? WIN_LIMIT : v;
			count = (eff == 0) ? 10 : eff + $urandom_range(15, 45);
			repeat (count) begin
				send_sample(pick_sample());
				if (eff != 0)
					sent++;
			end
			phase++;
		end

		drain();
		if (sb.errors == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end
endmodule

>>> filelist.f
+incdir+rtl
rtl/swm_pkg.sv
rtl/swm_ram.sv
rtl/sliding_window_median_top.sv
rtl/sliding_window_median_chk.sv
verif/sliding_window_median_top_test.sv
